/* hdl/pps_pkg.sv */
// shared types and constants for the preemptive priority scheduler
// no dependencies

package pps_pkg;

    localparam int ID_W    = 8;
    localparam int BURST_W = 16;
    localparam int PRIO_W  = 8;
    localparam int TIME_W  = 32;
    localparam int STAT_W  = 3;

    localparam logic [STAT_W-1:0] STAT_ADMITTED = 3'd0;
    localparam logic [STAT_W-1:0] STAT_FULL     = 3'd1;
    localparam logic [STAT_W-1:0] STAT_RAN      = 3'd2;
    localparam logic [STAT_W-1:0] STAT_DONE     = 3'd3;
    localparam logic [STAT_W-1:0] STAT_IDLE     = 3'd4;

    localparam logic REQ_ADMIT = 1'b0;
    localparam logic REQ_TICK  = 1'b1;

    typedef enum logic [2:0] {
        CTRL_IDLE,
        CTRL_SCAN,
        CTRL_DRAIN,
        CTRL_FETCH,
        CTRL_COMMIT
    } ctrl_state_t;

    typedef struct packed {
        logic start;
        logic scan;
        logic fetch;
        logic commit;
    } ctrl_cmd_t;

    typedef struct packed {
        logic scan_last;
        logic is_tick;
        logic out_free;
    } dp_status_t;

    typedef struct packed {
        logic [ID_W-1:0]    task_id;
        logic [PRIO_W-1:0]  prio;
        logic [TIME_W-1:0]  arrival;
        logic [BURST_W-1:0] remaining;
        logic [BURST_W-1:0] burst;
        logic [TIME_W-1:0]  start;
    } slot_entry_t;

endpackage

/* hdl/pps_ctrl.sv */
// controller state machine sequencing admit and tick requests
// depends on pps_pkg

module pps_ctrl import pps_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       req_accept,
    input  dp_status_t status,
    output ctrl_cmd_t  cmd,
    output logic       busy
);

    ctrl_state_t state_reg;
    ctrl_state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= CTRL_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            CTRL_IDLE: begin
                if (req_accept) begin
                    state_next = CTRL_SCAN;
                end
            end
            CTRL_SCAN: begin
                if (status.scan_last) begin
                    state_next = CTRL_DRAIN;
                end
            end
            CTRL_DRAIN: begin
                if (status.is_tick) begin
                    state_next = CTRL_FETCH;
                end else begin
                    state_next = CTRL_COMMIT;
                end
            end
            CTRL_FETCH: begin
                state_next = CTRL_COMMIT;
            end
            CTRL_COMMIT: begin
                if (status.out_free) begin
                    state_next = CTRL_IDLE;
                end
            end
            default: begin
                state_next = CTRL_IDLE;
            end
        endcase
    end

    always_comb begin
        cmd  = '0;
        busy = 1'b1;
        case (state_reg)
            CTRL_IDLE: begin
                busy      = 1'b0;
                cmd.start = req_accept;
            end
            CTRL_SCAN: begin
                cmd.scan = 1'b1;
            end
            CTRL_DRAIN: begin
                cmd = '0;
            end
            CTRL_FETCH: begin
                cmd.fetch = 1'b1;
            end
            CTRL_COMMIT: begin
                cmd.commit = status.out_free;
            end
            default: begin
                cmd = '0;
            end
        endcase
    end

endmodule

/* hdl/pps_dp.sv */
// datapath: slot table memory, valid bits, scan compare, tick counter, result register
// depends on pps_pkg

module pps_dp import pps_pkg::*; #(
    parameter int NUM_SLOTS = 16
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  ctrl_cmd_t           cmd,
    output dp_status_t          status,
    input  logic                in_req_type,
    input  logic [ID_W-1:0]     in_task_id,
    input  logic [BURST_W-1:0]  in_burst_len,
    input  logic [PRIO_W-1:0]   in_prio_level,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [STAT_W-1:0]   out_status,
    output logic [ID_W-1:0]     out_ran_id,
    output logic [TIME_W-1:0]   out_first_run_time,
    output logic [TIME_W-1:0]   out_finish_time,
    output logic [TIME_W-1:0]   out_turnaround
);

    localparam int IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int KEY_W = PRIO_W + TIME_W;

    slot_entry_t mem [NUM_SLOTS];
    slot_entry_t rd_data_reg;

    logic [NUM_SLOTS-1:0] valid_reg;
    logic [TIME_W-1:0]    now_reg;

    logic                 req_type_reg;
    logic [ID_W-1:0]      req_id_reg;
    logic [BURST_W-1:0]   req_burst_reg;
    logic [PRIO_W-1:0]    req_prio_reg;

    logic [IDX_W-1:0]     idx_reg;
    logic                 cmp_en_reg;
    logic [IDX_W-1:0]     cmp_idx_reg;
    logic                 best_found_reg;
    logic [IDX_W-1:0]     best_idx_reg;
    logic [KEY_W-1:0]     best_key_reg;
    logic                 free_found_reg;
    logic [IDX_W-1:0]     free_idx_reg;

    logic                 rd_en;
    logic [IDX_W-1:0]     rd_addr;
    logic [KEY_W-1:0]     cmp_key;
    logic                 cmp_valid;

    logic                 wr_en;
    logic [IDX_W-1:0]     wr_addr;
    slot_entry_t          wr_data;
    logic [TIME_W-1:0]    now_inc;
    logic [BURST_W-1:0]   rem_dec;
    logic [TIME_W-1:0]    start_sel;

    logic                 m_valid_reg;
    logic [STAT_W-1:0]    m_status_next;
    logic [ID_W-1:0]      m_id_next;
    logic [TIME_W-1:0]    m_first_next;
    logic [TIME_W-1:0]    m_finish_next;
    logic [TIME_W-1:0]    m_turn_next;
    logic [STAT_W-1:0]    m_status_reg;
    logic [ID_W-1:0]      m_id_reg;
    logic [TIME_W-1:0]    m_first_reg;
    logic [TIME_W-1:0]    m_finish_reg;
    logic [TIME_W-1:0]    m_turn_reg;

    assign status.scan_last = (idx_reg == IDX_W'(NUM_SLOTS - 1));
    assign status.is_tick   = (req_type_reg == REQ_TICK);
    assign status.out_free  = !m_valid_reg || out_ready;

    assign rd_en     = cmd.scan || cmd.fetch;
    assign rd_addr   = cmd.fetch ? best_idx_reg : idx_reg;
    assign cmp_key   = {rd_data_reg.prio, rd_data_reg.arrival};
    assign cmp_valid = valid_reg[cmp_idx_reg];

    // table memory, one write and one registered read port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // request capture and scan bookkeeping
    always_ff @(posedge aclk) begin
        if (cmd.start) begin
            req_type_reg  <= in_req_type;
            req_id_reg    <= in_task_id;
            req_burst_reg <= in_burst_len;
            req_prio_reg  <= in_prio_level;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg        <= '0;
            cmp_en_reg     <= 1'b0;
            cmp_idx_reg    <= '0;
            best_found_reg <= 1'b0;
            free_found_reg <= 1'b0;
            best_idx_reg   <= '0;
            free_idx_reg   <= '0;
            best_key_reg   <= '0;
        end else begin
            cmp_en_reg  <= cmd.scan;
            cmp_idx_reg <= idx_reg;
            if (cmd.start) begin
                idx_reg        <= '0;
                best_found_reg <= 1'b0;
                free_found_reg <= 1'b0;
            end else if (cmd.scan) begin
                idx_reg <= idx_reg + 1'b1;
            end
            if (cmp_en_reg) begin
                if (cmp_valid) begin
                    if (!best_found_reg || (cmp_key < best_key_reg)) begin
                        best_found_reg <= 1'b1;
                        best_idx_reg   <= cmp_idx_reg;
                        best_key_reg   <= cmp_key;
                    end
                end else if (!free_found_reg) begin
                    free_found_reg <= 1'b1;
                    free_idx_reg   <= cmp_idx_reg;
                end
            end
        end
    end

    // commit step: table update and result
    assign now_inc   = (now_reg == '1) ? now_reg : now_reg + 1'b1;
    assign rem_dec   = rd_data_reg.remaining - 1'b1;
    assign start_sel = (rd_data_reg.remaining == rd_data_reg.burst) ? now_reg
                                                                    : rd_data_reg.start;

    always_comb begin
        wr_en         = 1'b0;
        wr_addr       = free_idx_reg;
        wr_data       = rd_data_reg;
        m_status_next = STAT_IDLE;
        m_id_next     = '0;
        m_first_next  = '0;
        m_finish_next = '0;
        m_turn_next   = '0;
        if (req_type_reg == REQ_ADMIT) begin
            m_id_next = req_id_reg;
            if (free_found_reg) begin
                wr_en             = cmd.commit;
                wr_data.task_id   = req_id_reg;
                wr_data.prio      = req_prio_reg;
                wr_data.arrival   = now_reg;
                wr_data.remaining = (req_burst_reg == '0) ? BURST_W'(1) : req_burst_reg;
                wr_data.burst     = (req_burst_reg == '0) ? BURST_W'(1) : req_burst_reg;
                wr_data.start     = '0;
                m_status_next     = STAT_ADMITTED;
            end else begin
                m_status_next = STAT_FULL;
            end
        end else if (best_found_reg) begin
            wr_en             = cmd.commit;
            wr_addr           = best_idx_reg;
            wr_data.remaining = rem_dec;
            wr_data.start     = start_sel;
            m_id_next         = rd_data_reg.task_id;
            if (rem_dec == '0) begin
                m_status_next = STAT_DONE;
                m_first_next  = start_sel;
                m_finish_next = now_inc;
                m_turn_next   = now_inc - rd_data_reg.arrival;
            end else begin
                m_status_next = STAT_RAN;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg   <= '0;
            now_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cmd.commit) begin
                m_valid_reg <= 1'b1;
                if (req_type_reg == REQ_ADMIT) begin
                    if (free_found_reg) begin
                        valid_reg[free_idx_reg] <= 1'b1;
                    end
                end else begin
                    now_reg <= now_inc;
                    if (best_found_reg && (rem_dec == '0)) begin
                        valid_reg[best_idx_reg] <= 1'b0;
                    end
                end
            end else if (out_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.commit) begin
            m_status_reg <= m_status_next;
            m_id_reg     <= m_id_next;
            m_first_reg  <= m_first_next;
            m_finish_reg <= m_finish_next;
            m_turn_reg   <= m_turn_next;
        end
    end

    assign out_valid          = m_valid_reg;
    assign out_status         = m_status_reg;
    assign out_ran_id         = m_id_reg;
    assign out_first_run_time = m_first_reg;
    assign out_finish_time    = m_finish_reg;
    assign out_turnaround     = m_turn_reg;

endmodule

/* hdl/preemptive_priority_scheduler_unit.sv */
// top level of the preemptive priority scheduler
// depends on pps_pkg, pps_ctrl and pps_dp
//
// usage:
// s_ channel carries one request: tuser selects admit (0) or one tick (1),
// tdata holds task id, burst length and priority for an admit.
// m_ channel returns exactly one result per request: tuser is the status
// (admitted, table full, ran, ran and finished, idle), tdata holds the served
// id and, for a finished task, its first run time, finish time and turnaround.
// every request walks the whole slot table through the single read port of
// the slot memory, one slot a cycle, then passes a drain step, for a tick a
// fetch step, and the commit step that loads the result onto m_tvalid; a new
// request is taken in the idle state that follows that commit.
// the result sits in an output register; the next request is accepted while
// it waits, but its own result is held back until the receiver takes the old
// one, so a stalled receiver stalls the block after one request.
// reset clears all slot valid bits, the tick counter and the output register;
// slot contents need no clearing.

module preemptive_priority_scheduler_unit import pps_pkg::*; #(
    parameter int NUM_SLOTS = 16
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [31:0]  s_tdata,   // task_id[7:0], burst_len[23:8], prio_level[31:24]
    input  logic [0:0]   s_tuser,   // req_type[0]
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [103:0] m_tdata,   // ran_id[7:0], first_run_time[39:8],
                                    // finish_time[71:40], turnaround[103:72]
    output logic [2:0]   m_tuser    // status[2:0]
);

    ctrl_cmd_t  cmd;
    dp_status_t status;
    logic       busy;
    logic       req_accept;

    logic [ID_W-1:0]   ran_id;
    logic [TIME_W-1:0] first_run_time;
    logic [TIME_W-1:0] finish_time;
    logic [TIME_W-1:0] turnaround;

    assign s_tready   = !busy;
    assign req_accept = s_tvalid && !busy;

    pps_ctrl u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .req_accept (req_accept),
        .status     (status),
        .cmd        (cmd),
        .busy       (busy)
    );

    pps_dp #(
        .NUM_SLOTS (NUM_SLOTS)
    ) u_dp (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .cmd                (cmd),
        .status             (status),
        .in_req_type        (s_tuser[0]),
        .in_task_id         (s_tdata[7:0]),
        .in_burst_len       (s_tdata[23:8]),
        .in_prio_level      (s_tdata[31:24]),
        .out_valid          (m_tvalid),
        .out_ready          (m_tready),
        .out_status         (m_tuser),
        .out_ran_id         (ran_id),
        .out_first_run_time (first_run_time),
        .out_finish_time    (finish_time),
        .out_turnaround     (turnaround)
    );

    assign m_tdata = {turnaround, finish_time, first_run_time, ran_id};

endmodule

/* sim/tb_preemptive_priority_scheduler_unit.sv */
// testbench for preemptive_priority_scheduler_unit: queued requests driven with random gaps,
// results checked field by field against a slot table predictor kept in the bench
// depends on pps_pkg and the scheduler rtl
`timescale 1ns / 100ps

module tb_preemptive_priority_scheduler_unit import pps_pkg::*; ();

    localparam int SLOTS       = 16;
    localparam int CYCLE_LIMIT = 300000;
    localparam int DRAIN_WAIT  = 2 * (SLOTS + 4);
    localparam int RANDOM_REQS = 850;

    typedef struct {
        bit [0:0]         kind;
        bit [ID_W-1:0]    id;
        bit [BURST_W-1:0] burst;
        bit [PRIO_W-1:0]  prio;
        bit               hold;
    } sched_req_t;

    typedef struct {
        bit [STAT_W-1:0] status;
        bit [ID_W-1:0]   ran_id;
        bit [TIME_W-1:0] first_run;
        bit [TIME_W-1:0] finish;
        bit [TIME_W-1:0] turnaround;
    } sched_result_t;

    logic         aclk     = 1'b0;
    logic         aresetn  = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [31:0]  s_tdata  = '0;   // task_id[7:0], burst_len[23:8], prio_level[31:24]
    logic [0:0]   s_tuser  = '0;   // req_type[0]
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [103:0] m_tdata;         // ran_id[7:0], first_run_time[39:8],
                                   // finish_time[71:40], turnaround[103:72]
    logic [2:0]   m_tuser;         // status[2:0]

    sched_req_t    request_q[$];
    sched_result_t pending_results[$];
    sched_req_t    cur_req;
    int            err_cnt  = 0;
    int            cyc_cnt  = 0;
    int            sent_cnt = 0;
    int            recv_cnt = 0;
    int            gap_left = 0;
    int            stall_left = 0;
    bit            drv_busy = 1'b0;

    // predictor copy of the slot table
    bit               slot_used  [SLOTS];
    bit [ID_W-1:0]    slot_tid   [SLOTS];
    bit [PRIO_W-1:0]  slot_pri   [SLOTS];
    bit [TIME_W-1:0]  slot_arr   [SLOTS];
    bit [BURST_W-1:0] slot_left  [SLOTS];
    bit [BURST_W-1:0] slot_len   [SLOTS];
    bit [TIME_W-1:0]  slot_first [SLOTS];
    bit [TIME_W-1:0]  tick_now = '0;

    preemptive_priority_scheduler_unit #(
        .NUM_SLOTS (SLOTS)
    ) u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always #5 aclk = ~aclk;

    function automatic bit served_before(int a, int b);
        if (slot_pri[a] != slot_pri[b]) return slot_pri[a] < slot_pri[b];
        if (slot_arr[a] != slot_arr[b]) return slot_arr[a] < slot_arr[b];
        return a < b;
    endfunction

    function automatic void advance_tick();
        if (tick_now != '1) tick_now = tick_now + 1'b1;
    endfunction

    function automatic sched_result_t schedule_request(sched_req_t r);
        sched_result_t res;
        int            best;
        bit            found;
        res   = '{default: '0};
        best  = 0;
        found = 1'b0;
        if (r.kind == REQ_ADMIT) begin
            res.ran_id = r.id;
            for (int s = 0; s < SLOTS; s++) begin
                if (!found && !slot_used[s]) begin
                    found = 1'b1;
                    best  = s;
                end
            end
            if (!found) begin
                res.status = STAT_FULL;
                return res;
            end
            slot_used[best]  = 1'b1;
            slot_tid[best]   = r.id;
            slot_pri[best]   = r.prio;
            slot_arr[best]   = tick_now;
            slot_left[best]  = (r.burst == 0) ? 16'd1 : r.burst;
            slot_len[best]   = slot_left[best];
            slot_first[best] = '0;
            res.status = STAT_ADMITTED;
            return res;
        end
        for (int s = 0; s < SLOTS; s++) begin
            if (slot_used[s] && (!found || served_before(s, best))) begin
                best  = s;
                found = 1'b1;
            end
        end
        if (!found) begin
            res.status = STAT_IDLE;
            advance_tick();
            return res;
        end
        if (slot_left[best] == slot_len[best]) slot_first[best] = tick_now;
        slot_left[best] = slot_left[best] - 1'b1;
        advance_tick();
        res.ran_id = slot_tid[best];
        if (slot_left[best] == 0) begin
            slot_used[best] = 1'b0;
            res.status     = STAT_DONE;
            res.first_run  = slot_first[best];
            res.finish     = tick_now;
            res.turnaround = tick_now - slot_arr[best];
        end else begin
            res.status = STAT_RAN;
        end
        return res;
    endfunction

    function automatic void compare_field(string name, bit [TIME_W-1:0] want,
                                          logic [TIME_W-1:0] got);
        if (got !== want) begin
            $error("%s mismatch: expected %0h, got %0h", name, want, got);
            err_cnt++;
        end
    endfunction

    function automatic void push_admit(bit [ID_W-1:0] id, bit [BURST_W-1:0] burst,
                                       bit [PRIO_W-1:0] prio, bit hold);
        sched_req_t r;
        r = '{kind: REQ_ADMIT, id: id, burst: burst, prio: prio, hold: hold};
        request_q.insert(request_q.size(), r);
    endfunction

    function automatic void push_tick(bit hold);
        sched_req_t r;
        r = '{kind: REQ_TICK, id: ID_W'($urandom_range(0, 255)),
              burst: BURST_W'($urandom_range(0, 65535)),
              prio: PRIO_W'($urandom_range(0, 255)), hold: hold};
        request_q.insert(request_q.size(), r);
    endfunction

    // request driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            s_tuser  <= '0;
            drv_busy = 1'b0;
            gap_left = 0;
        end else begin
            if (s_tvalid && s_tready) begin
                pending_results.insert(pending_results.size(), schedule_request(cur_req));
                sent_cnt++;
                drv_busy = 1'b0;
                gap_left = (((sent_cnt / 80) % 3) == 1) ? 0 : $urandom_range(0, 4);
            end
            if (!drv_busy) begin
                if (gap_left > 0) begin
                    gap_left--;
                end else if (request_q.size() > 0 &&
                             !(request_q[0].hold && pending_results.size() != 0)) begin
                    cur_req  = request_q.pop_front();
                    drv_busy = 1'b1;
                    s_tdata  <= {cur_req.prio, cur_req.burst, cur_req.id};
                    s_tuser  <= cur_req.kind;
                end
            end
            s_tvalid <= drv_busy;
        end
    end

    // result monitor
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
            stall_left = 0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (pending_results.size() == 0) begin
                    $error("result with no request pending: status %0d", m_tuser);
                    err_cnt++;
                end else begin
                    sched_result_t want;
                    want = pending_results.pop_front();
                    compare_field("status", TIME_W'(want.status), TIME_W'(m_tuser));
                    compare_field("ran_id", TIME_W'(want.ran_id), TIME_W'(m_tdata[7:0]));
                    compare_field("first_run_time", want.first_run, m_tdata[39:8]);
                    compare_field("finish_time", want.finish, m_tdata[71:40]);
                    compare_field("turnaround", want.turnaround, m_tdata[103:72]);
                end
                recv_cnt++;
                stall_left = (((recv_cnt / 70) % 3) == 2) ? 0 : $urandom_range(0, 4);
            end else if (m_tvalid && stall_left > 0) begin
                stall_left--;
            end
            m_tready <= (stall_left == 0);
        end
    end

    always @(posedge aclk) begin
        cyc_cnt++;
        if (cyc_cnt >= CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial begin
        bit heavy;
        bit [BURST_W-1:0] burst;
        bit [PRIO_W-1:0]  prio;

        foreach (slot_used[s]) slot_used[s] = 1'b0;

        // idle tick, zero burst, a task that never completes, then fill the table
        push_tick(1'b0);
        push_admit(8'h00, 16'h0000, 8'h00, 1'b0);
        push_admit(8'hff, 16'hffff, 8'hff, 1'b0);
        push_tick(1'b0);
        for (int i = 0; i < 15; i++) begin
            case (i % 3)
                0: prio = 8'h03;
                1: prio = 8'h80;
                default: prio = 8'h40 | i[7:0];
            endcase
            push_admit(8'h10 + i[7:0], 16'(i % 3 + 1), prio, 1'b0);
        end
        push_admit(8'ha5, 16'h0005, 8'h01, 1'b0);
        repeat (5) push_tick(1'b0);

        // random mix, alternating admit-heavy and tick-heavy stretches
        for (int n = 0; n < RANDOM_REQS; n++) begin
            heavy = ((n / 60) % 2) == 0;
            if ($urandom_range(0, 99) < (heavy ? 40 : 15)) begin
                if ($urandom_range(0, 19) == 0) burst = '0;
                else if ($urandom_range(0, 15) == 0) burst = BURST_W'($urandom_range(5, 24));
                else burst = BURST_W'($urandom_range(1, 4));
                prio = ($urandom_range(0, 1) == 0) ? PRIO_W'($urandom_range(0, 7))
                                                   : PRIO_W'($urandom_range(0, 254));
                push_admit(ID_W'($urandom_range(0, 255)), burst, prio, (n % 150) == 0);
            end else begin
                push_tick((n % 150) == 0);
            end
        end

        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        while (request_q.size() != 0 || drv_busy) @(posedge aclk);
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_WAIT) @(posedge aclk);

        if (err_cnt == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
